@@ rtl/rotary_encoder_front_end_assert.svh @@
// Assertion macros shared by the rotary encoder front end.
`ifndef ROTARY_ENCODER_FRONT_END_ASSERT_SVH
`define ROTARY_ENCODER_FRONT_END_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define RENC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RENC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/renc_pkg.sv @@
// Types, register codes and the transition table of the rotary encoder front end.
package renc_pkg;

  localparam int unsigned CountW    = 8;
  localparam int unsigned TicksW    = 7;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 4;

  localparam logic [TicksW-1:0] TicksMin = 7'd1;
  localparam logic [TicksW-1:0] TicksMax = 7'd64;

  typedef enum logic [1:0] {
    RegTicksPerStep = 2'd0,
    RegDebounceMs   = 2'd1,
    RegPressedLevel = 2'd2,
    RegNone         = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [TicksW-1:0]    ticks_per_step;
    logic [DebounceW-1:0] debounce_ms;
    logic                 pressed_level;
  } cfg_t;

  typedef struct packed {
    logic                     last_a;
    logic                     last_b;
    logic signed [CountW-1:0] count;
    logic                     last_button_raw;
    logic [TimeW-1:0]         change_time;
    logic                     debounced;
  } state_t;

  typedef struct packed {
    logic             pin_a;
    logic             pin_b;
    logic             button_raw;
    logic [TimeW-1:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic                     step_up;
    logic                     step_down;
    logic                     press_pulse;
    logic                     button_level;
    logic signed [CountW-1:0] residual_count;
  } result_t;

  // Index is {last_a, last_b, pin_a, pin_b}.
  function automatic logic signed [1:0] move_delta(input logic [3:0] idx);
    logic signed [1:0] d;
    case (idx)
      4'b0011, 4'b1100, 4'b1000, 4'b0111: d = 2'sd1;
      4'b1001, 4'b0110, 4'b0010, 4'b1101: d = -2'sd1;
      default:                            d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/renc_in_if.sv @@
// Sample channel: encoder pins, raw button and millisecond time.
interface renc_in_if;
  logic        valid;
  logic        ready;
  logic        pin_a;
  logic        pin_b;
  logic        button_raw;
  logic [31:0] now_ms;

  modport source (output valid, pin_a, pin_b, button_raw, now_ms, input ready);
  modport sink   (input valid, pin_a, pin_b, button_raw, now_ms, output ready);
endinterface

@@ rtl/renc_out_if.sv @@
// Result channel: step pulses, button state and residual count.
interface renc_out_if;
  logic              valid;
  logic              ready;
  logic              step_up;
  logic              step_down;
  logic              press_pulse;
  logic              button_level;
  logic signed [7:0] residual_count;

  modport source (output valid, step_up, step_down, press_pulse, button_level,
                  residual_count, input ready);
  modport sink   (input valid, step_up, step_down, press_pulse, button_level,
                  residual_count, output ready);
endinterface

@@ rtl/renc_step.sv @@
// Per-sample update: quadrature table, step extraction and button debounce.
module renc_step
  import renc_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  sample_t sample_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [TicksW-1:0]        ticks;
  logic signed [1:0]        delta;
  logic signed [CountW:0]   count_mv;
  logic signed [CountW:0]   ticks_s;
  logic signed [CountW:0]   count_nx;
  logic                     up;
  logic                     down;
  logic [TimeW-1:0]         change_nx;
  logic [TimeW-1:0]         elapsed;
  logic                     deb_nx;
  logic                     pulse;

  always_comb begin
    if (cfg_i.ticks_per_step < TicksMin) begin
      ticks = TicksMin;
    end else if (cfg_i.ticks_per_step > TicksMax) begin
      ticks = TicksMax;
    end else begin
      ticks = cfg_i.ticks_per_step;
    end
  end

  assign delta    = move_delta({state_i.last_a, state_i.last_b,
                                sample_i.pin_a, sample_i.pin_b});
  assign ticks_s  = $signed({2'b00, ticks});
  assign count_mv = {state_i.count[CountW-1], state_i.count}
                  + {{(CountW-1){delta[1]}}, delta};

  always_comb begin
    up       = 1'b0;
    down     = 1'b0;
    count_nx = count_mv;
    if (count_mv >= ticks_s) begin
      count_nx = count_mv - ticks_s;
      up       = 1'b1;
    end else if (count_mv <= -ticks_s) begin
      count_nx = count_mv + ticks_s;
      down     = 1'b1;
    end
  end

  // Debounce tests the raw level held before this sample.
  assign change_nx = (sample_i.button_raw != state_i.last_button_raw) ?
                     sample_i.now_ms : state_i.change_time;
  assign elapsed   = sample_i.now_ms - change_nx;

  always_comb begin
    deb_nx = state_i.debounced;
    pulse  = 1'b0;
    if (elapsed > {{(TimeW-DebounceW){1'b0}}, cfg_i.debounce_ms}) begin
      if (state_i.last_button_raw == cfg_i.pressed_level) begin
        pulse  = ~state_i.debounced;
        deb_nx = 1'b1;
      end else begin
        deb_nx = 1'b0;
      end
    end
  end

  always_comb begin
    state_o.last_a          = sample_i.pin_a;
    state_o.last_b          = sample_i.pin_b;
    state_o.count           = count_nx[CountW-1:0];
    state_o.last_button_raw = sample_i.button_raw;
    state_o.change_time     = change_nx;
    state_o.debounced       = deb_nx;

    result_o.step_up        = up;
    result_o.step_down      = down;
    result_o.press_pulse    = pulse;
    result_o.button_level   = deb_nx;
    result_o.residual_count = count_nx[CountW-1:0];
  end

endmodule

@@ rtl/rotary_encoder_front_end.sv @@
// Top level of the rotary encoder front end with debounced push button.
//
// Usage:
//   in_ch  : one item per sample of pin A, pin B, the raw button and now_ms.
//   out_ch : one item per input item: step up/down pulses, the press pulse,
//            the debounced button level and the residual position count.
//   APB    : ticks_per_step at 0x0, debounce_ms at 0x4, pressed_level at 0x8.
//            pready is tied high; reads return the stored value.
// Timing:
//   An item is held in the input register, is evaluated by the
//   step logic and lands in the result register, which drives
//   out_ch.valid. One item per cycle is sustained while out_ch.ready stays
//   high; the only loop is the state update of the step logic.
// Reset:
//   rst_ni clears both pipeline valids, the encoder and button state and
//   loads the register defaults (4, 50, 0).
// Stalls:
//   While out_ch.ready is low the result register holds, the input register
//   keeps one more item, and in_ch.ready drops only once both are full.
//   Configuration changes take effect on the next item evaluated.
module rotary_encoder_front_end
  import renc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  renc_in_if.sink             in_ch,
  renc_out_if.source          out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  `include "rotary_encoder_front_end_assert.svh"

  // ---------------- configuration registers ----------------
  cfg_t       cfg_q, cfg_d;
  reg_index_e reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_e'(paddr[ApbAddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        RegTicksPerStep: cfg_d.ticks_per_step = pwdata[TicksW-1:0];
        RegDebounceMs:   cfg_d.debounce_ms    = pwdata[DebounceW-1:0];
        RegPressedLevel: cfg_d.pressed_level  = pwdata[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegTicksPerStep: prdata = {{(ApbDataW-TicksW){1'b0}}, cfg_q.ticks_per_step};
      RegDebounceMs:   prdata = {{(ApbDataW-DebounceW){1'b0}}, cfg_q.debounce_ms};
      RegPressedLevel: prdata = {{(ApbDataW-1){1'b0}}, cfg_q.pressed_level};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_step <= 7'd4;
      cfg_q.debounce_ms    <= 16'd50;
      cfg_q.pressed_level  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- pipeline control ----------------
  logic    in_valid_q, in_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    in_take;
  logic    advance;
  sample_t sample_q;
  result_t result_q;
  result_t result_nx;
  state_t  state_q, state_nx;

  // Input register moves on whenever the result slot is free or draining.
  assign advance        = in_valid_q & (~out_valid_q | out_ch.ready);
  assign in_ch.ready    = ~in_valid_q | advance;
  assign in_take        = in_ch.valid & in_ch.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_nx;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q.pin_a      <= in_ch.pin_a;
      sample_q.pin_b      <= in_ch.pin_b;
      sample_q.button_raw <= in_ch.button_raw;
      sample_q.now_ms     <= in_ch.now_ms;
    end
    if (advance) begin
      result_q <= result_nx;
    end
  end

  renc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .sample_i (sample_q),
    .state_o  (state_nx),
    .result_o (result_nx)
  );

  assign out_ch.valid          = out_valid_q;
  assign out_ch.step_up        = result_q.step_up;
  assign out_ch.step_down      = result_q.step_down;
  assign out_ch.press_pulse    = result_q.press_pulse;
  assign out_ch.button_level   = result_q.button_level;
  assign out_ch.residual_count = result_q.residual_count;

  // ---------------- assertions ----------------
  `RENC_ASSERT(a_one_step_dir, clk_i, rst_ni,
               out_valid_q |-> !(result_q.step_up && result_q.step_down),
               "step up and step down in the same item")
  `RENC_ASSERT(a_pulse_level, clk_i, rst_ni,
               out_valid_q && result_q.press_pulse |-> result_q.button_level,
               "press pulse without debounced level")
  `RENC_ASSERT(a_count_range, clk_i, rst_ni,
               advance |=> (result_q.residual_count >= -8'sd64) &&
                           (result_q.residual_count <= 8'sd64),
               "residual count out of range")
  `RENC_ASSERT(a_hold_pending, clk_i, rst_ni,
               in_valid_q && out_valid_q && !out_ch.ready |=> in_valid_q,
               "pending item dropped while output stalled")

endmodule
